[rtl/spc_pkg.sv]
// ----------------------------------------------------------------------------
// Scanline polygon span package
// Operation codes and shared types for the span core.
// ----------------------------------------------------------------------------
package spc_pkg;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	// divider request from the walker
	typedef struct packed {
		logic go;
		logic neg;
	} div_ctl_t;

endpackage

[rtl/spc_div.sv]
// ----------------------------------------------------------------------------
// Span divider
// Restoring divider, one quotient bit per cycle. Computes floor-correct
// quotient and remainder of num / den for unsigned operands, then applies
// sign and rounds half away from zero, adding base.
// ----------------------------------------------------------------------------
module spc_div #(
	parameter int NW = 34,
	parameter int DW = 18,
	parameter int RW = 20
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  spc_pkg::div_ctl_t    ctl,
	input  logic [NW-1:0]        num,
	input  logic [DW-1:0]        den,
	input  logic signed [RW-1:0] base,
	output logic                 done,
	output logic signed [RW-1:0] value
);
	import spc_pkg::*;

	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] quo_q;
	logic [DW:0]   rem_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          neg_q;
	logic          run_q;
	logic signed [RW-1:0] base_q;
	logic [DW:0]   trial;
	logic [DW:0]   shifted;

	assign shifted = {rem_q[DW-1:0], quo_q[NW-1]};
	assign trial   = shifted - {1'b0, den_q};

	// iterate one bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (ctl.go) begin
				run_q <= 1'b1;
				cnt_q <= CW'(NW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.go) begin
			quo_q  <= num;
			rem_q  <= '0;
			den_q  <= den;
			neg_q  <= ctl.neg;
			base_q <= base;
		end else if (run_q) begin
			if (!trial[DW]) begin
				rem_q <= trial;
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

	// sign, round half away from zero, add base
	logic signed [RW-1:0] qs, v0;
	logic [DW:0]          rs;
	logic [DW+1:0]        rs2;
	logic                 rnz;
	always_comb begin
		rnz = (rem_q != '0);
		if (!neg_q) begin
			qs = RW'(signed'({1'b0, quo_q}));
			rs = rem_q;
		end else begin
			qs = -RW'(signed'({1'b0, quo_q})) - RW'(rnz);
			rs = rnz ? ({1'b0, den_q} - rem_q) : '0;
		end
		v0  = base_q + qs;
		rs2 = {rs, 1'b0};
		if (rs2 > {2'b0, den_q} || (rs2 == {2'b0, den_q} && rs != '0 && !v0[RW-1]))
			value = v0 + RW'(1);
		else
			value = v0;
	end
endmodule

[rtl/scanline_polygon_span_core.sv]
// ----------------------------------------------------------------------------
// Scanline polygon span core
// Edge table with a sequential span query over the stored edges.
// ----------------------------------------------------------------------------
// channel | handshake      | payload
// input   | start / busy   | operation, edge_*, scan_position, scan_horizontal
// result  | strobe         | span_first, span_second, hit_count, table_full
// Clear and append are taken in the accept cycle and busy stays low; an append
// result shows on strobe in the next cycle. A query reads and examines the edges
// in turn in the read and examine states; each interpolated edge then passes
// through the multiply, divider load and divide states. Strobe rises as busy falls.
// Reset empties the edge count; table contents are undefined until written.
// The receiver cannot stall: each result shows for one cycle on strobe.
// ----------------------------------------------------------------------------
module scanline_polygon_span_core #(
	parameter int MAX_EDGES  = 16,
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   operation,
	input  logic signed [COORD_BITS-1:0] edge_start_x,
	input  logic signed [COORD_BITS-1:0] edge_start_y,
	input  logic signed [COORD_BITS-1:0] edge_end_x,
	input  logic signed [COORD_BITS-1:0] edge_end_y,
	input  logic signed [COORD_BITS-1:0] scan_position,
	input  logic                         scan_horizontal,
	output logic                         strobe,
	output logic signed [COORD_BITS-1:0] span_first,
	output logic signed [COORD_BITS-1:0] span_second,
	output logic [1:0]                   hit_count,
	output logic                         table_full
);
	import spc_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int NB = $clog2(MAX_EDGES + 1);
	localparam int DW = CB + 1;          // |difference|
	localparam int NW = 2 * DW;          // |t*w|
	localparam int RW = CB + 3;          // result before truncation

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_READ  = 3'd1;
	localparam logic [2:0] ST_EXAM  = 3'd2;
	localparam logic [2:0] ST_MUL   = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;
	localparam logic [2:0] ST_LOAD  = 3'd6;

	logic [2:0]          state_q;
	logic [NB-1:0]       count_q;
	logic [NB-1:0]       idx_q;
	logic signed [CB-1:0] pos_q;
	logic                horiz_q;
	logic [1:0]          hits_q;
	logic signed [RW-1:0] first_q, second_q;

	// edge memory
	logic [4*CB-1:0] mem [MAX_EDGES];
	logic [4*CB-1:0] rd_q;

	logic acc;
	assign acc  = start && !busy;
	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk) begin
		if (acc && operation == OP_APPEND && count_q < NB'(MAX_EDGES))
			mem[count_q[AW-1:0]] <= {edge_start_x, edge_start_y, edge_end_x, edge_end_y};
		rd_q <= mem[idx_q[AW-1:0]];
	end

	// decode the current edge
	logic signed [CB-1:0] ax, ay, bx, by, u0, u1, c0, c1, lo, hi;
	always_comb begin
		{ax, ay, bx, by} = rd_q;
		u0 = horiz_q ? ax : ay;
		u1 = horiz_q ? bx : by;
		c0 = horiz_q ? ay : ax;
		c1 = horiz_q ? by : bx;
		lo = (u0 < u1) ? u0 : u1;
		hi = (u0 < u1) ? u1 : u0;
	end

	// operand registers for multiply and divide
	logic signed [DW-1:0] t_s1, w_s1, d_s1;
	logic signed [CB-1:0] c0_s1;
	logic [NW-1:0]        prod_s2;
	logic                 neg_s2;
	logic [DW-1:0]        dabs_s2;
	div_ctl_t             dctl;
	logic                 ddone;
	logic signed [RW-1:0] dval;

	logic [DW-1:0] ta, wa;
	logic signed [DW-1:0] tn, dn;
	always_comb begin
		tn = d_s1[DW-1] ? -t_s1 : t_s1;
		dn = d_s1[DW-1] ? -d_s1 : d_s1;
		ta = tn[DW-1] ? DW'(-tn) : DW'(tn);
		wa = w_s1[DW-1] ? DW'(-w_s1) : DW'(w_s1);
	end

	// load the divider once the product register holds the operands
	assign dctl.go  = (state_q == ST_LOAD);
	assign dctl.neg = neg_s2;

	spc_div #(.NW(NW), .DW(DW), .RW(RW)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (dctl),
		.num   (prod_s2),
		.den   (dabs_s2),
		.base  (RW'(c0_s1)),
		.done  (ddone),
		.value (dval)
	);

	logic signed [RW-1:0] fa, fb;
	always_comb begin
		fa = first_q;
		fb = second_q;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			hits_q      <= '0;
			pos_q       <= '0;
			horiz_q     <= 1'b0;
			first_q     <= '0;
			second_q    <= '0;
			t_s1        <= '0;
			w_s1        <= '0;
			d_s1        <= '0;
			c0_s1       <= '0;
			span_first  <= '0;
			span_second <= '0;
			hit_count   <= '0;
			table_full  <= 1'b0;
			strobe      <= 1'b0;
		end else begin
			strobe <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						priority if (operation == OP_CLEAR) begin
							count_q <= '0;
						end else if (operation == OP_APPEND) begin
							table_full  <= (count_q >= NB'(MAX_EDGES));
							if (count_q < NB'(MAX_EDGES))
								count_q <= count_q + 1'b1;
							span_first  <= '1;
							span_second <= '1;
							hit_count   <= '0;
							strobe      <= 1'b1;
						end else if (operation == OP_QUERY) begin
							pos_q    <= scan_position;
							horiz_q  <= scan_horizontal;
							idx_q    <= '0;
							hits_q   <= '0;
							first_q  <= '1;
							second_q <= '1;
							state_q  <= ST_READ;
						end
					end
				end
				ST_READ: begin
					state_q <= (idx_q >= count_q) ? ST_DONE : ST_EXAM;
				end
				ST_EXAM: begin
					if (pos_q < lo || pos_q > hi) begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_READ;
					end else if (u0 == u1) begin
						first_q  <= RW'(c0);
						second_q <= RW'(c1);
						hits_q   <= 2'd2;
						state_q  <= ST_DONE;
					end else begin
						t_s1    <= DW'(pos_q) - DW'(u0);
						w_s1    <= DW'(c1) - DW'(c0);
						d_s1    <= DW'(u1) - DW'(u0);
						c0_s1   <= c0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL:  state_q <= ST_LOAD;
				ST_LOAD: state_q <= ST_DIV;
				ST_DIV: begin
					if (ddone) begin
						if (hits_q == 2'd0) begin
							first_q <= dval;
							hits_q  <= 2'd1;
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_READ;
						end else begin
							second_q <= dval;
							hits_q   <= 2'd2;
							state_q  <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					span_first  <= (fa > fb) ? CB'(fb) : CB'(fa);
					span_second <= (fa > fb) ? CB'(fa) : CB'(fb);
					hit_count   <= hits_q;
					table_full  <= 1'b0;
					strobe      <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// multiply stage: registered operands for the divider
	always_ff @(posedge clk) begin
		if (state_q == ST_EXAM) begin
			prod_s2 <= '0;
		end else begin
			prod_s2 <= NW'(ta) * NW'(wa);
			neg_s2  <= tn[DW-1] != w_s1[DW-1];
			dabs_s2 <= DW'(dn);
		end
	end
endmodule

[rtl/spc_check.sv]
// ----------------------------------------------------------------------------
// Span core checker
// Port-level properties of the span core, bound to the top level.
// ----------------------------------------------------------------------------
module spc_check (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] operation,
	input logic       strobe,
	input logic [1:0] hit_count,
	input logic       table_full
);
	import spc_pkg::*;

	// append results carry no hits
	a_app: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && table_full |-> hit_count == 2'd0) else $error("full with hits");
	// hit count never three
	a_hit: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> hit_count != 2'd3) else $error("bad hit count");
	// an append produces a result next cycle
	a_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && operation == OP_APPEND |=> strobe) else $error("no append result");
	// clear gives no result
	a_clr: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && operation == OP_CLEAR |=> !strobe) else $error("clear result");
endmodule

bind scanline_polygon_span_core spc_check u_spc_check (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.operation(operation), .strobe(strobe), .hit_count(hit_count),
	.table_full(table_full)
);

[bench/tb_scanline_polygon_span_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scanline polygon span core testbench
// Loads random polygon edge tables and queries spans in both directions. A
// behavioral span finder predicts every result. Results are checked in order
// against the expected spans.
// ----------------------------------------------------------------------------
module tb_scanline_polygon_span_core;
	import spc_pkg::*;

	localparam int MAX_EDGES  = 16;
	localparam int COORD_BITS = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct {
		logic [1:0]         op;
		logic signed [15:0] ax, ay, bx, by;
		logic signed [15:0] pos;
		logic               horiz;
	} item_t;

	typedef struct {
		logic signed [15:0] first, second;
		logic [1:0]         hits;
		logic               full;
	} span_t;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic [1:0] operation = OP_CLEAR;
	logic signed [15:0] edge_start_x = 0, edge_start_y = 0, edge_end_x = 0, edge_end_y = 0;
	logic signed [15:0] scan_position = 0;
	logic scan_horizontal = 0;
	logic strobe;
	logic signed [15:0] span_first, span_second;
	logic [1:0] hit_count;
	logic table_full;

	scanline_polygon_span_core #(.MAX_EDGES(MAX_EDGES), .COORD_BITS(COORD_BITS)) dut (.*);

	always #5 clk = ~clk;

	item_t pending_items[$];
	span_t expected_spans[$];
	int errors = 0;
	int cycle_count = 0;
	int gap_left = 0;
	bit calm = 0;
	bit stim_done = 0;

	// predictor copy of the edge table
	longint tab_ax[MAX_EDGES], tab_ay[MAX_EDGES], tab_bx[MAX_EDGES], tab_by[MAX_EDGES];
	int edge_num = 0;

	// append to the pending item queue
	task automatic add_item(input item_t it);
		pending_items = {pending_items, it};
	endtask

	// base + t*w/d, rounded half away from zero
	function automatic longint interp_round(longint base, longint t, longint w, longint d);
		longint num, q, r, v;
		if (d < 0) begin
			d = -d;
			t = -t;
		end
		num = t * w;
		q = num / d;
		r = num % d;
		if (r < 0) begin
			q = q - 1;
			r = r + d;
		end
		v = base + q;
		if (2 * r > d || (2 * r == d && r != 0 && v >= 0))
			v++;
		return v;
	endfunction

	// advance the span finder by one item
	task automatic predict_span(input item_t it);
		span_t s;
		longint first, second, tmp, pos, u0, u1, c0, c1, lo, hi;
		int hits;
		s.hits = 0;
		s.full = 0;
		s.first = -1;
		s.second = -1;
		if (it.op == OP_CLEAR) begin
			edge_num = 0;
		end else if (it.op == OP_APPEND) begin
			if (edge_num >= MAX_EDGES) begin
				s.full = 1;
			end else begin
				tab_ax[edge_num] = it.ax;
				tab_ay[edge_num] = it.ay;
				tab_bx[edge_num] = it.bx;
				tab_by[edge_num] = it.by;
				edge_num++;
			end
			expected_spans = {expected_spans, s};
		end else if (it.op == OP_QUERY) begin
			first = -1;
			second = -1;
			hits = 0;
			pos = it.pos;
			for (int k = 0; k < edge_num; k++) begin
				u0 = it.horiz ? tab_ax[k] : tab_ay[k];
				u1 = it.horiz ? tab_bx[k] : tab_by[k];
				c0 = it.horiz ? tab_ay[k] : tab_ax[k];
				c1 = it.horiz ? tab_by[k] : tab_bx[k];
				lo = u0 < u1 ? u0 : u1;
				hi = u0 < u1 ? u1 : u0;
				if (pos < lo || pos > hi)
					continue;
				if (u0 == u1) begin
					first = c0;
					second = c1;
					hits = 2;
					break;
				end
				if (hits == 0) begin
					first = interp_round(c0, pos - u0, c1 - c0, u1 - u0);
					hits = 1;
				end else begin
					second = interp_round(c0, pos - u0, c1 - c0, u1 - u0);
					hits = 2;
					break;
				end
			end
			if (first > second) begin
				tmp = first;
				first = second;
				second = tmp;
			end
			s.first = first[15:0];
			s.second = second[15:0];
			s.hits = hits[1:0];
			expected_spans = {expected_spans, s};
		end
	endtask

	function automatic logic signed [15:0] rand_coord(int spread);
		case ($urandom_range(0, 9))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'($urandom);
			default: return 16'(int'($urandom_range(0, 2 * spread)) - spread);
		endcase
	endfunction

	function automatic item_t make_item(logic [1:0] op, int ax, int ay, int bx, int by,
			int pos, logic horiz);
		item_t it;
		it.op = op;
		it.ax = 16'(ax);
		it.ay = 16'(ay);
		it.bx = 16'(bx);
		it.by = 16'(by);
		it.pos = 16'(pos);
		it.horiz = horiz;
		return it;
	endfunction

	// fill the item queue: directed part, then random polygons and queries
	initial begin
		item_t it;
		int spread, n;
		add_item(make_item(OP_QUERY, 0, 0, 0, 0, 0, 0));
		add_item(make_item(OP_APPEND, -32768, -32768, 32767, 32767, 0, 0));
		add_item(make_item(OP_APPEND, 32767, -32768, -32768, 32767, 0, 0));
		add_item(make_item(OP_QUERY, 0, 0, 0, 0, 0, 0));
		add_item(make_item(OP_QUERY, 0, 0, 0, 0, 32767, 1));
		add_item(make_item(OP_QUERY, 0, 0, 0, 0, -32768, 0));
		add_item(make_item(OP_QUERY, 0, 0, 0, 0, 3, 1));
		add_item(make_item(OP_UNUSED, 1, 2, 3, 4, 5, 1));
		add_item(make_item(OP_CLEAR, 0, 0, 0, 0, 0, 0));
		// edge along the scan line, point edge, vertical edge, half rounding
		add_item(make_item(OP_APPEND, 0, 0, 3, 1, 0, 0));
		add_item(make_item(OP_APPEND, -5, 0, -1, 2, 0, 0));
		add_item(make_item(OP_APPEND, 7, -4, 7, 9, 0, 0));
		add_item(make_item(OP_APPEND, 4, 4, 4, 4, 0, 0));
		add_item(make_item(OP_APPEND, 2, 5, 9, 5, 0, 0));
		add_item(make_item(OP_QUERY, 0, 0, 0, 0, 1, 0));
		add_item(make_item(OP_QUERY, 0, 0, 0, 0, 1, 1));
		add_item(make_item(OP_QUERY, 0, 0, 0, 0, 4, 0));
		add_item(make_item(OP_QUERY, 0, 0, 0, 0, 5, 0));
		add_item(make_item(OP_QUERY, 0, 0, 0, 0, 7, 1));
		add_item(make_item(OP_QUERY, 0, 0, 0, 0, 100, 1));
		for (int k = 0; k < 13; k++)
			add_item(make_item(OP_APPEND, k, -k, 3 * k, k, 0, 0));
		add_item(make_item(OP_QUERY, 0, 0, 0, 0, 2, 1));
		// random polygons: clear, load edges, query a few scan lines
		while (pending_items.size() < 600) begin
			spread = ($urandom_range(0, 3) == 0) ? 32767 : $urandom_range(4, 200);
			add_item(make_item(OP_CLEAR, 0, 0, 0, 0, 0, 0));
			n = $urandom_range(0, 6) == 0 ? $urandom_range(15, 19) : $urandom_range(1, 6);
			for (int k = 0; k < n; k++) begin
				it = make_item(OP_APPEND, rand_coord(spread), rand_coord(spread),
					rand_coord(spread), rand_coord(spread), 0, 0);
				if ($urandom_range(0, 7) == 0)
					it.by = it.ay;
				if ($urandom_range(0, 7) == 0)
					it.bx = it.ax;
				it.pos = 16'($urandom);
				add_item(it);
			end
			n = $urandom_range(1, 6);
			for (int k = 0; k < n; k++) begin
				it = make_item(OP_QUERY, $urandom, $urandom, $urandom, $urandom,
					rand_coord(spread), 1'($urandom_range(0, 1)));
				if ($urandom_range(0, 15) == 0)
					it.op = OP_UNUSED;
				add_item(it);
			end
		end
	end

	// drive items into the core, with random idle bursts
	always @(posedge clk) begin
		item_t it;
		cycle_count <= cycle_count + 1;
		if (arst_n) begin
			if (start && !busy) begin
				predict_span(pending_items.pop_front());
				if (pending_items.size() < 40)
					calm <= 1;
			end
			if (!start || !busy) begin
				if (pending_items.size() == 0) begin
					start <= 0;
					stim_done <= 1;
				end else if (gap_left > 0 && !calm) begin
					gap_left <= gap_left - 1;
					start <= 0;
				end else if (!calm && $urandom_range(0, 5) == 0) begin
					gap_left <= $urandom_range(1, 16);
					start <= 0;
				end else begin
					it = pending_items[0];
					start <= 1;
					operation <= it.op;
					edge_start_x <= it.ax;
					edge_start_y <= it.ay;
					edge_end_x <= it.bx;
					edge_end_y <= it.by;
					scan_position <= it.pos;
					scan_horizontal <= it.horiz;
				end
			end
		end
	end

	// compare each strobed result with the oldest expected span
	always @(posedge clk) begin
		span_t s;
		if (arst_n && strobe) begin
			if (expected_spans.size() == 0) begin
				$error("unexpected result: first %0d second %0d", span_first, span_second);
				errors++;
			end else begin
				s = expected_spans.pop_front();
				if (span_first !== s.first) begin
					$error("span_first expected %0d actual %0d", s.first, span_first);
					errors++;
				end
				if (span_second !== s.second) begin
					$error("span_second expected %0d actual %0d", s.second, span_second);
					errors++;
				end
				if (hit_count !== s.hits) begin
					$error("hit_count expected %0d actual %0d", s.hits, hit_count);
					errors++;
				end
				if (table_full !== s.full) begin
					$error("table_full expected %0d actual %0d", s.full, table_full);
					errors++;
				end
			end
		end
	end

	// hold reset, then wait for the queues to drain
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1;
		while (!(stim_done && expected_spans.size() == 0 && !start)
				&& cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("scanline_polygon_span_core regression: fail");
		end else begin
			repeat (200) @(posedge clk);
			if (errors == 0 && expected_spans.size() == 0)
				$display("scanline_polygon_span_core regression: pass");
			else
				$display("scanline_polygon_span_core regression: fail");
		end
		$finish;
	end

endmodule
